// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define FKG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// checked at every edge
`define FKG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/fkg_pkg.sv =====
`timescale 1ns / 1ps

package fkg_pkg;

    localparam int MAX_ITEMS_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 16;
    localparam int VAL_W             = 16;
    localparam int CAP_W             = 24;
    localparam int IDX_W             = 6;
    localparam int FRAC_OUT_W        = 17;
    localparam int WORD_W            = 2 * VAL_W;

    typedef struct packed {
        logic [VAL_W-1:0] profit;
        logic [VAL_W-1:0] weight;
        logic             last;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]      item_index;
        logic [FRAC_OUT_W-1:0] fraction;
        logic                  final_result;
    } t_out_item;

endpackage

// ===== rtl/core/fkg_ram.sv =====
`timescale 1ns / 1ps

module fkg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/fractional_knapsack_greedy.sv =====
`timescale 1ns / 1ps
// Fractional knapsack solver. Items (profit, weight, last) are taken one per
// cycle while ready into the item store. The item flagged last starts a run
// against the capacity written beforehand, and the block is not ready until
// all of the run's results have been taken. Each result slot is found by a
// scan over all n stored items, one candidate at a time through the store's
// read port and a cross-multiply compare (S_MUL, then S_CMP). Each slot starts
// with S_ISSUE and ends with S_PICK, a bit-serial divide (S_DIV) when its item
// is split, and S_OUT, which waits for the result to be taken. Results come in
// order of falling profit/weight ratio, equal ratios in load order. The
// fraction is Q1.FRACTION_BITS, and 1.0 means the whole item.

`include "assert_macros.svh"

module fractional_knapsack_greedy #(
    parameter int MAX_ITEMS     = fkg_pkg::MAX_ITEMS_DEF,
    parameter int FRACTION_BITS = fkg_pkg::FRACTION_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [fkg_pkg::CAP_W-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  fkg_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output fkg_pkg::t_out_item              o_out_data
);

    import fkg_pkg::*;

    localparam int AW  = $clog2(MAX_ITEMS);
    localparam int CW  = $clog2(MAX_ITEMS + 1);
    localparam int DCW = $clog2(FRACTION_BITS + 1);
    localparam int PW  = 2 * VAL_W;
    localparam logic [FRAC_OUT_W-1:0] FracWhole =
        FRAC_OUT_W'((64'd1 << FRACTION_BITS) & 64'h1FFFF);

    typedef enum logic [6:0] {
        S_LOAD  = 7'b0000001,
        S_ISSUE = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_PICK  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state                 r_state;
    logic [CAP_W-1:0]       r_capacity;
    logic [CAP_W-1:0]       r_rem;
    logic [CW-1:0]          r_count;
    logic [AW-1:0]          r_slot;
    logic [AW-1:0]          r_cand_idx;
    logic [MAX_ITEMS-1:0]   r_taken;
    logic                   r_have_best;
    logic                   r_partial;
    logic [AW-1:0]          r_best_idx;
    logic [VAL_W-1:0]       r_best_p;
    logic [VAL_W-1:0]       r_best_w;
    logic [VAL_W-1:0]       r_cand_p;
    logic [VAL_W-1:0]       r_cand_w;
    logic [PW-1:0]          r_lhs;
    logic [PW-1:0]          r_rhs;
    logic [FRAC_OUT_W-1:0]  r_frac;
    logic [VAL_W:0]         r_div_rem;
    logic [FRACTION_BITS-1:0] r_quot;
    logic [DCW-1:0]         r_div_cnt;

    logic                   in_acc;
    logic                   out_acc;
    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [WORD_W-1:0]      ram_rdata;
    logic [VAL_W-1:0]       in_w;
    logic [VAL_W-1:0]       rd_p;
    logic [VAL_W-1:0]       rd_w;
    logic                   cand_last;
    logic                   slot_last;
    logic                   take_cand;
    logic [VAL_W:0]         div_shift;
    logic                   div_ge;
    logic [FRACTION_BITS-1:0] n_quot;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OUT);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_acc     = o_out_valid && i_out_ready;
    assign in_w        = (i_in_data.weight == '0) ? VAL_W'(1) : i_in_data.weight;
    assign ram_we      = in_acc && (r_count < CW'(MAX_ITEMS));
    assign ram_re      = (r_state == S_ISSUE) || ((r_state == S_CMP) && !cand_last);
    assign ram_raddr   = (r_state == S_ISSUE) ? '0 : r_cand_idx + AW'(1);
    assign rd_p        = ram_rdata[WORD_W-1:VAL_W];
    assign rd_w        = ram_rdata[VAL_W-1:0];
    assign cand_last   = (CW'(r_cand_idx) == r_count - CW'(1));
    assign slot_last   = (CW'(r_slot) == r_count - CW'(1));
    assign take_cand   = !r_taken[r_cand_idx] && (!r_have_best || (r_lhs > r_rhs));
    assign div_shift   = {r_div_rem[VAL_W-1:0], 1'b0};
    assign div_ge      = (div_shift >= {1'b0, r_best_w});
    assign n_quot      = {r_quot[FRACTION_BITS-2:0], div_ge};

    fkg_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_ITEMS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(r_count)),
        .i_wdata ({i_in_data.profit, in_w}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_capacity <= '0;
            r_rem      <= '0;
            r_count    <= '0;
            r_slot     <= '0;
            r_taken    <= '0;
            r_have_best <= 1'b0;
            r_partial  <= 1'b0;
            r_div_cnt  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            unique case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (ram_we) begin
                            r_count <= r_count + CW'(1);
                        end
                        if (i_in_data.last) begin
                            r_state     <= S_ISSUE;
                            r_rem       <= r_capacity;
                            r_taken     <= '0;
                            r_slot      <= '0;
                            r_partial   <= 1'b0;
                            r_have_best <= 1'b0;
                        end
                    end
                end
                S_ISSUE: begin
                    r_cand_idx <= '0;
                    r_state    <= S_MUL;
                end
                S_MUL: begin
                    r_cand_p <= rd_p;
                    r_cand_w <= rd_w;
                    r_lhs    <= {{VAL_W{1'b0}}, rd_p} * {{VAL_W{1'b0}}, r_best_w};
                    r_rhs    <= {{VAL_W{1'b0}}, r_best_p} * {{VAL_W{1'b0}}, rd_w};
                    r_state  <= S_CMP;
                end
                S_CMP: begin
                    if (take_cand) begin
                        r_have_best <= 1'b1;
                        r_best_idx  <= r_cand_idx;
                        r_best_p    <= r_cand_p;
                        r_best_w    <= r_cand_w;
                    end
                    if (cand_last) begin
                        r_state <= S_PICK;
                    end else begin
                        r_cand_idx <= r_cand_idx + AW'(1);
                        r_state    <= S_MUL;
                    end
                end
                S_PICK: begin
                    r_taken[r_best_idx] <= 1'b1;
                    if (r_partial) begin
                        r_frac  <= '0;
                        r_state <= S_OUT;
                    end else if ({{(CAP_W-VAL_W){1'b0}}, r_best_w} <= r_rem) begin
                        r_frac  <= FracWhole;
                        r_rem   <= r_rem - {{(CAP_W-VAL_W){1'b0}}, r_best_w};
                        r_state <= S_OUT;
                    end else begin
                        r_partial <= 1'b1;
                        r_div_rem <= {1'b0, r_rem[VAL_W-1:0]};
                        r_div_cnt <= '0;
                        r_state   <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_div_rem <= div_ge ? (div_shift - {1'b0, r_best_w}) : div_shift;
                    r_quot    <= n_quot;
                    r_div_cnt <= r_div_cnt + DCW'(1);
                    if (r_div_cnt == DCW'(FRACTION_BITS - 1)) begin
                        r_frac  <= FRAC_OUT_W'(n_quot);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_have_best <= 1'b0;
                        if (slot_last) begin
                            r_count <= '0;
                            r_state <= S_LOAD;
                        end else begin
                            r_slot  <= r_slot + AW'(1);
                            r_state <= S_ISSUE;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase
        end
    end

    always_comb begin
        o_out_data.item_index   = IDX_W'(r_best_idx);
        o_out_data.fraction     = r_frac;
        o_out_data.final_result = slot_last;
    end

    `FKG_ASSERT(a_slot_in_range, i_clk, i_rst_n, (r_state == S_OUT) |-> (CW'(r_slot) < r_count), "result slot beyond item count")
    `FKG_ASSERT(a_div_only_partial, i_clk, i_rst_n, (r_state == S_DIV) |-> r_partial, "divide without partial item")
    `FKG_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid), "input taken during output")
    `FKG_ASSERT(a_ready_after_run, i_clk, i_rst_n, (out_acc && o_out_data.final_result) |=> (o_in_ready && (r_count == '0)), "not ready after final result")

endmodule

// ===== tb/sv/fractional_knapsack_greedy_tb.sv =====
`timescale 1ns / 1ps

class knapsack_scoreboard;
    logic [15:0] profit_q[$];
    logic [15:0] weight_q[$];
    logic [23:0] capacity;
    fkg_pkg::t_out_item expected_q[$];
    int errors;
    int results_seen;
    int sets_done;

    function new();
        capacity = 0;
        errors = 0;
        results_seen = 0;
        sets_done = 0;
    endfunction

    function void set_capacity(logic [23:0] c);
        capacity = c;
    endfunction

    // stores the item (up to 64); on last, sorts and fills
    function void note_item(fkg_pkg::t_in_item it);
        logic [15:0] p[64];
        logic [15:0] w[64];
        logic [5:0] ix[64];
        logic [15:0] tp, tw;
        logic [5:0] tix;
        logic [31:0] lhs, rhs;
        logic [23:0] remaining;
        logic [39:0] quot;
        logic [16:0] frac;
        bit partial_done;
        int n;
        fkg_pkg::t_out_item r;
        if (profit_q.size() < 64) begin
            profit_q.push_back(it.profit);
            weight_q.push_back(it.weight == 0 ? 16'd1 : it.weight);
        end
        if (!it.last) return;
        n = profit_q.size();
        for (int k = 0; k < n; k++) begin
            p[k] = profit_q[k];
            w[k] = weight_q[k];
            ix[k] = k[5:0];
        end
        for (int i = 0; i + 1 < n; i++)
            for (int j = 0; j + 1 < n - i; j++) begin
                lhs = p[j] * w[j+1];
                rhs = p[j+1] * w[j];
                if (lhs < rhs) begin
                    tp = p[j]; tw = w[j]; tix = ix[j];
                    p[j] = p[j+1]; w[j] = w[j+1]; ix[j] = ix[j+1];
                    p[j+1] = tp; w[j+1] = tw; ix[j+1] = tix;
                end
            end
        remaining = capacity;
        partial_done = 0;
        for (int k = 0; k < n; k++) begin
            if (partial_done) begin
                frac = 0;
            end else if (w[k] <= remaining) begin
                frac = 17'h10000;
                remaining = remaining - w[k];
            end else begin
                quot = {remaining, 16'h0} / w[k];
                frac = quot[16:0];
                partial_done = 1;
            end
            r.item_index = ix[k];
            r.fraction = frac;
            r.final_result = (k + 1 == n);
            expected_q.push_back(r);
        end
        profit_q.delete();
        weight_q.delete();
        sets_done++;
    endfunction

    function void report(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endfunction

    function void check_result(fkg_pkg::t_out_item got);
        fkg_pkg::t_out_item want;
        results_seen++;
        if (expected_q.size() == 0) begin
            report("unexpected result index", got.item_index, -1);
            return;
        end
        want = expected_q.pop_front();
        if (got.item_index != want.item_index)
            report("item_index", got.item_index, want.item_index);
        if (got.fraction != want.fraction)
            report("fraction", got.fraction, want.fraction);
        if (got.final_result != want.final_result)
            report("final_result", got.final_result, want.final_result);
    endfunction
endclass

module fractional_knapsack_greedy_tb;
    import fkg_pkg::*;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CAP_W-1:0] i_cfg_data;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out_data;

    knapsack_scoreboard sb;
    int items_sent;
    bit stall_free;

    fractional_knapsack_greedy uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_data(i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data(o_out_data)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("timeout");
        $display("** fractional_knapsack_greedy: FAILED **");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (stall_free || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // result side: accept, check, idle at random
    initial begin
        i_out_ready = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            i_out_ready <= (gap_len() == 0);
            @(posedge i_clk);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    task automatic send_item(logic [15:0] p, logic [15:0] w, logic l);
        t_in_item it;
        int g;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 0;
            repeat (g) @(posedge i_clk);
        end
        it.profit = p;
        it.weight = w;
        it.last = l;
        i_in_valid <= 1;
        i_in_data <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        i_in_valid <= 0;
        while (sb.expected_q.size() != 0 && guard < 400000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [23:0] c);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.set_capacity(c);
    endtask

    task automatic random_set(int n, int mode);
        logic [15:0] p, w;
        for (int k = 0; k < n; k++) begin
            case (mode)
                0: begin p = 16'($urandom); w = 16'($urandom); end
                1: begin
                    p = 16'($urandom_range(0, 15));
                    w = 16'($urandom_range(0, 15));
                end
                default: begin
                    p = 16'($urandom_range(1, 4) * 100);
                    w = 16'($urandom_range(1, 4) * 50);
                end
            endcase
            send_item(p, w, k == n - 1);
        end
    endtask

    initial begin
        sb = new();
        items_sent = 0;
        stall_free = 0;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = '0;
        i_in_valid = 0;
        i_in_data = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // capacity zero: everything gets fraction zero
        send_item(16'd10, 16'd5, 0);
        send_item(16'hFFFF, 16'hFFFF, 1);
        write_capacity(24'd100);
        send_item(16'd60, 16'd10, 0);
        send_item(16'd100, 16'd20, 0);
        send_item(16'd120, 16'd30, 0);
        send_item(16'd30, 16'd15, 0);
        send_item(16'd0, 16'd0, 0);
        send_item(16'd12, 16'd6, 1);
        send_item(16'd7, 16'd0, 1);
        write_capacity(24'hFFFFFF);
        send_item(16'hFFFF, 16'd1, 0);
        send_item(16'd0, 16'hFFFF, 0);
        send_item(16'h8000, 16'h8000, 1);
        write_capacity(24'd50);
        send_item(16'd5, 16'd10, 0);
        send_item(16'd10, 16'd20, 0);
        send_item(16'd5, 16'd10, 1);
        write_capacity(24'd1);
        send_item(16'd3, 16'd3, 0);
        send_item(16'd9, 16'd7, 1);

        // overflow: 66 items, two dropped
        write_capacity(24'd300);
        random_set(66, 1);

        stall_free = 1;
        write_capacity(24'd40000);
        random_set(12, 0);
        stall_free = 0;

        while (items_sent < 210) begin
            write_capacity(24'($urandom_range(0, 3) == 0 ? $urandom
                                                         : $urandom_range(0, 200000)));
            random_set($urandom_range(1, 10), $urandom_range(0, 2));
        end
        drain();
        repeat (200) @(posedge i_clk);
        $display("%0d items in %0d data sets, %0d results checked, %0d mismatches",
                 items_sent, sb.sets_done, sb.results_seen, sb.errors);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("** fractional_knapsack_greedy: PASSED **");
        end else begin
            $display("** fractional_knapsack_greedy: FAILED **");
        end
        $finish;
    end
endmodule

// ===== fractional_knapsack_greedy.f =====
+incdir+rtl/core
rtl/core/fkg_pkg.sv
rtl/core/fkg_ram.sv
rtl/core/fractional_knapsack_greedy.sv
tb/sv/fractional_knapsack_greedy_tb.sv
